[design/pli_pkg.sv]
// Shared types and constants for the piecewise linear interpolator.
`default_nettype none

package pli_pkg;

  localparam int MAX_POINTS_DEF = 256;
  localparam int VALUE_BITS     = 32;
  localparam int COUNT_BITS     = 9;
  localparam int SEG_BITS       = 8;
  localparam int PROD_BITS      = 2 * VALUE_BITS;
  localparam int DIV_STEPS      = 2;
  localparam int DIV_CELLS      = PROD_BITS / DIV_STEPS;

  localparam logic [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOW,
    ST_HIGH,
    ST_ADDR,
    ST_CMP,
    ST_RDA,
    ST_RDB,
    ST_DIFF,
    ST_MUL,
    ST_LAUNCH,
    ST_DIV,
    ST_SUM,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] position;
    logic signed [VALUE_BITS-1:0] level;
  } entry_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] rem;
    logic [PROD_BITS-1:0]  word;
    logic [VALUE_BITS-1:0] divisor;
  } div_t;

endpackage

`default_nettype wire

[design/pli_item_if.sv]
// Input channel: one load or query transaction.
`default_nettype none

interface pli_item_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  point_index;
  logic signed [31:0] position;
  logic signed [31:0] level;

  modport source (output valid, output opcode, output point_index, output position,
                  output level, input ready);
  modport sink   (input valid, input opcode, input point_index, input position,
                  input level, output ready);
endinterface

`default_nettype wire

[design/pli_result_if.sv]
// Output channel: one interpolation result transaction.
`default_nettype none

interface pli_result_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] value;
  logic [7:0]  segment;
  logic        clamped_low;
  logic        clamped_high;

  modport source (output valid, output value, output segment, output clamped_low,
                  output clamped_high, input ready);
  modport sink   (input valid, input value, input segment, input clamped_low,
                  input clamped_high, output ready);
endinterface

`default_nettype wire

[design/pli_table.sv]
// Breakpoint table: one write port, one registered read port.
`default_nettype none

module pli_table #(
  parameter  int MAX_POINTS = pli_pkg::MAX_POINTS_DEF,
  localparam int AW         = $clog2(MAX_POINTS)
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire pli_pkg::entry_t wdata_i,
  input  wire logic [AW-1:0]   raddr_i,
  output pli_pkg::entry_t      rdata_o
);

  pli_pkg::entry_t mem_q [MAX_POINTS];
  pli_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/pli_div_cell.sv]
// Divider cell: restoring division steps on a quotient word, registered to the next cell.
`default_nettype none

module pli_div_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire pli_pkg::div_t data_i,
  output logic               valid_o,
  output pli_pkg::div_t      data_o
);

  localparam int VB = pli_pkg::VALUE_BITS;
  localparam int PB = pli_pkg::PROD_BITS;

  logic          valid_q;
  pli_pkg::div_t data_q;
  pli_pkg::div_t data_d;

  always_comb begin
    logic [VB-1:0] r;
    logic [PB-1:0] w;
    logic [VB:0]   t;
    r = data_i.rem;
    w = data_i.word;
    for (int k = 0; k < pli_pkg::DIV_STEPS; k++) begin
      t = {r, w[PB-1]};
      w = {w[PB-2:0], 1'b0};
      if (t >= {1'b0, data_i.divisor}) begin
        t    = t - {1'b0, data_i.divisor};
        w[0] = 1'b1;
      end
      r = t[VB-1:0];
    end
    data_d.rem     = r;
    data_d.word    = w;
    data_d.divisor = data_i.divisor;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[design/piecewise_linear_interpolator.sv]
// Piecewise linear interpolator top level: table, search sequencer, divider cell chain.
//
// A load transaction writes one breakpoint (position, level); slots at or above MAX_POINTS
// are dropped. A query transaction is clamped against the first and the last active breakpoint
// (point_count, reset 1), otherwise located by binary search and interpolated with a 32x32
// multiply and a 64/32 divide that truncates toward zero, saturated to signed Q16.16. The block
// works on one query at a time: a low clamp is decided in the state after acceptance and a high
// clamp in the state after that; an interpolating query runs the search with an address and a
// compare state per step for the registered table read, then goes through the chain of divider
// cells at 2 quotient bits per cell. The result sits in an output register, so the next
// transaction is taken while it waits. Table entries have no reset and must be loaded before a
// query reads them.
`default_nettype none

module piecewise_linear_interpolator #(
  parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  pli_item_if.sink                              item_i,
  pli_result_if.source                          result_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [pli_pkg::COUNT_BITS-1:0]   cfg_wdata_i
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int VB = pli_pkg::VALUE_BITS;
  localparam int PB = pli_pkg::PROD_BITS;
  localparam int NC = pli_pkg::DIV_CELLS;

  function automatic logic [VB-1:0] mag(input logic [VB:0] d);
    logic [VB:0] n;
    n = ~d + {{VB{1'b0}}, 1'b1};
    return d[VB] ? n[VB-1:0] : d[VB-1:0];
  endfunction

  pli_pkg::state_e state_q, state_d;
  logic [pli_pkg::COUNT_BITS-1:0] count_q;

  logic [CW-1:0] n_eff;
  logic [AW-1:0] last_eff;
  logic [AW-1:0] lo_eff;

  logic signed [VB-1:0] q_q;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0] mid_q, mid_d, idx_q, raddr;
  pli_pkg::entry_t base_q, rdata, wdata;
  logic [VB-1:0] mdy_q, mdq_q, mdx_q;
  logic          neg_q;
  logic [PB-1:0] prod_q, quo_q;
  logic [VB:0]   dy_w, dq_w, dx_w;
  logic [VB+2:0] sum_w, base_x, addend;

  logic          item_acc, tbl_we;
  logic          res_load;
  logic [VB-1:0] res_value_d, res_value_q;
  logic [pli_pkg::SEG_BITS-1:0] res_seg_d, res_seg_q;
  logic          res_clo_d, res_clo_q, res_chi_d, res_chi_q;

  logic          out_valid_q, out_valid_d, out_load;
  logic [VB-1:0] out_value_q;
  logic [pli_pkg::SEG_BITS-1:0] out_seg_q;
  logic          out_clo_q, out_chi_q;

  logic          chain_valid [NC+1];
  pli_pkg::div_t chain_data  [NC+1];

  // effective point count: 0 acts as 1, clipped to the table depth
  always_comb begin
    if (count_q == '0) begin
      n_eff = CW'(1);
    end else if (int'(count_q) > MAX_POINTS) begin
      n_eff = CW'(MAX_POINTS);
    end else begin
      n_eff = CW'(count_q);
    end
  end

  assign last_eff = AW'(n_eff - CW'(1));
  assign lo_eff   = (lo_q > CW'(last_eff)) ? last_eff : AW'(lo_q);

  assign item_acc = item_i.valid && item_i.ready;
  assign tbl_we   = item_acc && (item_i.opcode == pli_pkg::OP_LOAD)
                    && (int'(item_i.point_index) < MAX_POINTS);
  assign wdata.position = item_i.position;
  assign wdata.level    = item_i.level;

  pli_table #(
    .MAX_POINTS (MAX_POINTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (AW'(item_i.point_index)),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign dy_w = {rdata.level[VB-1], rdata.level} - {base_q.level[VB-1], base_q.level};
  assign dq_w = {q_q[VB-1], q_q} - {base_q.position[VB-1], base_q.position};
  assign dx_w = {rdata.position[VB-1], rdata.position}
                - {base_q.position[VB-1], base_q.position};

  assign base_x = {{3{base_q.level[VB-1]}}, base_q.level};
  assign addend = {2'b00, quo_q[VB:0]};
  assign sum_w  = neg_q ? (base_x - addend) : (base_x + addend);

  always_comb begin
    state_d     = state_q;
    res_load    = 1'b0;
    res_value_d = rdata.level;
    res_seg_d   = '0;
    res_clo_d   = 1'b0;
    res_chi_d   = 1'b0;
    raddr       = '0;
    mid_d       = AW'(lo_q + ((hi_q - lo_q) >> 1));
    lo_d        = lo_q;
    hi_d        = hi_q;
    out_load    = 1'b0;
    unique case (state_q)
      pli_pkg::ST_IDLE: begin
        if (item_acc && (item_i.opcode == pli_pkg::OP_QUERY)) begin
          state_d = pli_pkg::ST_LOW;
        end
      end
      pli_pkg::ST_LOW: begin
        raddr = last_eff;
        if (q_q <= rdata.position) begin
          res_load  = 1'b1;
          res_clo_d = 1'b1;
          state_d   = pli_pkg::ST_DONE;
        end else begin
          state_d = pli_pkg::ST_HIGH;
        end
      end
      pli_pkg::ST_HIGH: begin
        if (q_q >= rdata.position) begin
          res_load  = 1'b1;
          res_seg_d = pli_pkg::SEG_BITS'(last_eff);
          res_chi_d = 1'b1;
          state_d   = pli_pkg::ST_DONE;
        end else begin
          state_d = pli_pkg::ST_ADDR;
        end
      end
      pli_pkg::ST_ADDR: begin
        raddr   = mid_d;
        state_d = pli_pkg::ST_CMP;
      end
      pli_pkg::ST_CMP: begin
        if (rdata.position < q_q) begin
          lo_d = CW'(mid_q) + CW'(1);
        end else begin
          hi_d = CW'(mid_q);
        end
        state_d = (lo_d < hi_d) ? pli_pkg::ST_ADDR : pli_pkg::ST_RDA;
      end
      pli_pkg::ST_RDA: begin
        raddr   = (lo_eff == '0) ? '0 : lo_eff - AW'(1);
        state_d = pli_pkg::ST_RDB;
      end
      pli_pkg::ST_RDB: begin
        raddr = idx_q;
        if (idx_q == '0) begin
          res_load = 1'b1;
          state_d  = pli_pkg::ST_DONE;
        end else begin
          state_d = pli_pkg::ST_DIFF;
        end
      end
      pli_pkg::ST_DIFF: begin
        state_d = pli_pkg::ST_MUL;
      end
      pli_pkg::ST_MUL: begin
        if (mdx_q == '0) begin
          res_load    = 1'b1;
          res_value_d = base_q.level;
          res_seg_d   = pli_pkg::SEG_BITS'(idx_q);
          state_d     = pli_pkg::ST_DONE;
        end else begin
          state_d = pli_pkg::ST_LAUNCH;
        end
      end
      pli_pkg::ST_LAUNCH: begin
        state_d = pli_pkg::ST_DIV;
      end
      pli_pkg::ST_DIV: begin
        if (chain_valid[NC]) begin
          state_d = pli_pkg::ST_SUM;
        end
      end
      pli_pkg::ST_SUM: begin
        res_load  = 1'b1;
        res_seg_d = pli_pkg::SEG_BITS'(idx_q);
        if (|quo_q[PB-1:VB+1]) begin
          res_value_d = neg_q ? pli_pkg::VAL_MIN : pli_pkg::VAL_MAX;
        end else if ((sum_w[VB+2:VB-1] == '0) || (sum_w[VB+2:VB-1] == '1)) begin
          res_value_d = sum_w[VB-1:0];
        end else begin
          res_value_d = sum_w[VB+2] ? pli_pkg::VAL_MIN : pli_pkg::VAL_MAX;
        end
        state_d = pli_pkg::ST_DONE;
      end
      pli_pkg::ST_DONE: begin
        if (!out_valid_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = pli_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pli_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (result_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pli_pkg::ST_IDLE;
      count_q     <= pli_pkg::COUNT_BITS'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      pli_pkg::ST_IDLE: begin
        if (item_acc) begin
          q_q <= item_i.position;
        end
      end
      pli_pkg::ST_HIGH: begin
        lo_q <= '0;
        hi_q <= n_eff;
      end
      pli_pkg::ST_ADDR: mid_q <= mid_d;
      pli_pkg::ST_CMP: begin
        lo_q <= lo_d;
        hi_q <= hi_d;
      end
      pli_pkg::ST_RDA: idx_q <= lo_eff;
      pli_pkg::ST_RDB: base_q <= rdata;
      pli_pkg::ST_DIFF: begin
        mdy_q <= mag(dy_w);
        mdq_q <= mag(dq_w);
        mdx_q <= mag(dx_w);
        neg_q <= dy_w[VB] ^ dq_w[VB] ^ dx_w[VB];
      end
      pli_pkg::ST_MUL: prod_q <= PB'(mdy_q) * PB'(mdq_q);
      pli_pkg::ST_DIV: begin
        if (chain_valid[NC]) begin
          quo_q <= chain_data[NC].word;
        end
      end
      default: ;
    endcase
    if (res_load) begin
      res_value_q <= res_value_d;
      res_seg_q   <= res_seg_d;
      res_clo_q   <= res_clo_d;
      res_chi_q   <= res_chi_d;
    end
    if (out_load) begin
      out_value_q <= res_value_q;
      out_seg_q   <= res_seg_q;
      out_clo_q   <= res_clo_q;
      out_chi_q   <= res_chi_q;
    end
  end

  // divider: chain of cells, quotient bits shift in from the bottom of the word
  assign chain_valid[0] = (state_q == pli_pkg::ST_LAUNCH);
  assign chain_data[0]  = '{rem: '0, word: prod_q, divisor: mdx_q};

  for (genvar c = 0; c < NC; c++) begin : g_div
    pli_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[c]),
      .data_i  (chain_data[c]),
      .valid_o (chain_valid[c+1]),
      .data_o  (chain_data[c+1])
    );
  end

  assign item_i.ready          = (state_q == pli_pkg::ST_IDLE);
  assign result_o.valid        = out_valid_q;
  assign result_o.value        = out_value_q;
  assign result_o.segment      = out_seg_q;
  assign result_o.clamped_low  = out_clo_q;
  assign result_o.clamped_high = out_chi_q;

endmodule

`default_nettype wire

[design/pli_checker.sv]
// Port-level checks for the piecewise linear interpolator, bound to the top level.
`default_nettype none

module pli_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] value_i,
  input wire logic [7:0]  segment_i,
  input wire logic        clamped_low_i,
  input wire logic        clamped_high_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transaction");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(value_i) && $stable(segment_i)
      && $stable(clamped_low_i) && $stable(clamped_high_i))
    else $error("result payload changed while stalled");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(clamped_low_i && clamped_high_i))
    else $error("both clamp flags set");

  a_low_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && clamped_low_i |-> segment_i == 8'd0)
    else $error("low clamp with nonzero segment");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_valid_i && in_ready_i)
      && !$past(in_valid_i && in_ready_i, 2))
    else $error("result appeared too soon after a transaction");

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (item_i.valid),
  .in_ready_i     (item_i.ready),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .value_i        (result_o.value),
  .segment_i      (result_o.segment),
  .clamped_low_i  (result_o.clamped_low),
  .clamped_high_i (result_o.clamped_high)
);

`default_nettype wire
